FILE: design/eight_bit_cpu_core_subset_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 8-bit CPU core subset
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_CORE_SUBSET_ASSERT_SVH
`define EIGHT_BIT_CPU_CORE_SUBSET_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EBC_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EBC_ASSERT(label, clk, rst_n, prop, msg)
`define EBC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: design/ebc_pkg.sv
// ---------------------------------------------------------------------------
// ebc_pkg
// Shared types and constants of the 8-bit CPU core subset.
// ---------------------------------------------------------------------------
package ebc_pkg;

    localparam logic [3:0] PH_RESET = 4'd0;
    localparam logic [3:0] PH_FETCH = 4'd1;
    localparam logic [3:0] PH_OP2   = 4'd2;
    localparam logic [3:0] PH_OP3   = 4'd3;
    localparam logic [3:0] PH_OP4   = 4'd4;
    localparam logic [3:0] PH_OP5   = 4'd5;

    localparam logic [7:0]  CB_PREFIX = 8'hCB;
    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [3:0]  flags;
        logic [3:0]  phase;
        logic [7:0]  opcode;
        logic [15:0] operand;
        logic        prefix;
    } cpu_state_t;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic        done;
        logic [4:0]  cycles;
        logic        bad;
    } bus_req_t;

endpackage

FILE: design/ebc_exec.sv
// ---------------------------------------------------------------------------
// ebc_exec
// Next-state logic: one bus cycle step of the CPU from state and read data.
// ---------------------------------------------------------------------------
module ebc_exec
(
    input  ebc_pkg::cpu_state_t cur,
    input  logic [7:0]          rdata,
    output ebc_pkg::cpu_state_t nxt,
    output ebc_pkg::bus_req_t   req
);

    function automatic logic [7:0] get_r(input ebc_pkg::cpu_state_t s, input logic [2:0] i);
        case (i)
            3'd0: get_r = s.a;
            3'd1: get_r = s.b;
            3'd2: get_r = s.c;
            3'd3: get_r = s.d;
            3'd4: get_r = s.e;
            3'd5: get_r = s.h;
            3'd6: get_r = s.l;
            default: get_r = s.a;
        endcase
    endfunction

    function automatic ebc_pkg::cpu_state_t set_r(input ebc_pkg::cpu_state_t s,
                                                  input logic [2:0] i, input logic [7:0] v);
        ebc_pkg::cpu_state_t t;
        t = s;
        case (i)
            3'd0: t.a = v;
            3'd1: t.b = v;
            3'd2: t.c = v;
            3'd3: t.d = v;
            3'd4: t.e = v;
            3'd5: t.h = v;
            3'd6: t.l = v;
            default: t.a = v;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] sub_flags(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] r;
        r = x - y;
        return {r == 8'd0, 1'b1, x[3:0] < y[3:0], x < y};
    endfunction

    logic [2:0]  sel;
    logic [7:0]  sel_val;
    logic [7:0]  inc_v;
    logic [7:0]  dec_v;
    logic [15:0] word;
    logic [15:0] rel_pc;
    logic [8:0]  add_s;
    logic [4:0]  add_h;
    logic [15:0] hl;
    logic [15:0] de;

    assign sel     = (rdata[5:3] == 3'd7) ? 3'd0 : rdata[5:3] + 3'd1;
    assign sel_val = get_r(cur, sel);
    assign inc_v   = sel_val + 8'd1;
    assign dec_v   = sel_val - 8'd1;
    assign word    = {rdata, cur.operand[7:0]};
    assign rel_pc  = cur.pc + {{8{rdata[7]}}, rdata};
    assign add_s   = {1'b0, cur.a} + {1'b0, rdata};
    assign add_h   = {1'b0, cur.a[3:0]} + {1'b0, rdata[3:0]};
    assign hl      = {cur.h, cur.l};
    assign de      = {cur.d, cur.e};

    always_comb
    begin
        nxt = cur;
        req = '0;
        // default: fetch the next opcode
        req.addr = cur.pc;
        nxt.pc   = cur.pc + 16'd1;
        nxt.phase = ebc_pkg::PH_FETCH;
        case (cur.phase)
            ebc_pkg::PH_FETCH:
            begin
                if (cur.prefix)
                begin
                    nxt.prefix = 1'b0;
                    req.done = 1'b1;
                    req.cycles = 5'd8;
                    case (rdata)
                        8'h11:
                        begin
                            nxt.c = {cur.c[6:0], cur.flags[0]};
                            nxt.flags = {{cur.c[6:0], cur.flags[0]} == 8'd0, 2'b00, cur.c[7]};
                        end
                        8'h7C: nxt.flags = {~cur.h[7], 2'b01, cur.flags[0]};
                        default:
                        begin
                            req.cycles = 5'd4;
                            req.bad = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    nxt.opcode = rdata;
                    req.done = 1'b1;
                    req.cycles = 5'd4;
                    case (rdata)
                        8'h04, 8'h0C, 8'h14, 8'h1C, 8'h24, 8'h3C:
                        begin
                            nxt = set_r(nxt, sel, inc_v);
                            nxt.flags = {inc_v == 8'd0, 1'b0, sel_val[3:0] == 4'hF,
                                         cur.flags[0]};
                        end
                        8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25, 8'h3D:
                        begin
                            nxt = set_r(nxt, sel, dec_v);
                            nxt.flags = {dec_v == 8'd0, 1'b1, sel_val[3:0] == 4'h0,
                                         cur.flags[0]};
                        end
                        8'h06, 8'h0E, 8'h16, 8'h1E, 8'h2E, 8'h3E, 8'h18, 8'h20, 8'h28,
                        8'hE0, 8'hF0, 8'hFE, 8'h11, 8'h21, 8'h31, 8'hEA, 8'hCD:
                        begin
                            req.done = 1'b0;
                            req.cycles = 5'd0;
                            nxt.phase = ebc_pkg::PH_OP2;
                        end
                        8'h13:
                        begin
                            {nxt.d, nxt.e} = de + 16'd1;
                            req.cycles = 5'd8;
                        end
                        8'h23:
                        begin
                            {nxt.h, nxt.l} = hl + 16'd1;
                            req.cycles = 5'd8;
                        end
                        8'h17:
                        begin
                            nxt.a = {cur.a[6:0], cur.flags[0]};
                            nxt.flags = {3'b000, cur.a[7]};
                        end
                        8'h1A, 8'h86, 8'hBE, 8'h22, 8'h32, 8'h77, 8'hE2, 8'hC1, 8'hC9,
                        8'hC5:
                        begin
                            req.done = 1'b0;
                            req.cycles = 5'd0;
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP2;
                            case (rdata)
                                8'h1A: req.addr = de;
                                8'h86, 8'hBE: req.addr = hl;
                                8'hE2:
                                begin
                                    req.addr = ebc_pkg::HIGH_PAGE | {8'd0, cur.c};
                                    req.wr = 1'b1;
                                    req.wdata = cur.a;
                                end
                                8'hC1, 8'hC9:
                                begin
                                    req.addr = cur.sp;
                                    nxt.sp = cur.sp + 16'd1;
                                end
                                8'hC5:
                                begin
                                    req.addr = cur.sp - 16'd1;
                                    nxt.sp = cur.sp - 16'd1;
                                    req.wr = 1'b1;
                                    req.wdata = cur.b;
                                end
                                default:
                                begin
                                    req.addr = hl;
                                    req.wr = 1'b1;
                                    req.wdata = cur.a;
                                    if (rdata == 8'h22)
                                        {nxt.h, nxt.l} = hl + 16'd1;
                                    else if (rdata == 8'h32)
                                        {nxt.h, nxt.l} = hl - 16'd1;
                                end
                            endcase
                        end
                        8'h4F, 8'h57, 8'h67: nxt = set_r(nxt, sel, cur.a);
                        8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D:
                            nxt.a = get_r(cur, rdata[2:0] + 3'd1);
                        8'h90:
                        begin
                            nxt.a = cur.a - cur.b;
                            nxt.flags = sub_flags(cur.a, cur.b);
                        end
                        8'hAF:
                        begin
                            nxt.a = 8'd0;
                            nxt.flags = 4'b1000;
                        end
                        ebc_pkg::CB_PREFIX:
                        begin
                            req.done = 1'b0;
                            req.cycles = 5'd0;
                            nxt.prefix = 1'b1;
                        end
                        default: req.bad = 1'b1;
                    endcase
                end
            end
            ebc_pkg::PH_OP2, ebc_pkg::PH_OP3, ebc_pkg::PH_OP4, ebc_pkg::PH_OP5:
            begin
                case (cur.opcode)
                    8'h06, 8'h0E, 8'h16, 8'h1E, 8'h2E, 8'h3E:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt = set_r(nxt, (cur.opcode[5:3] == 3'd7) ? 3'd0
                                        : cur.opcode[5:3] + 3'd1, rdata);
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                        end
                    8'h18, 8'h20, 8'h28:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                            if (cur.opcode == 8'h18 || ((cur.opcode == 8'h28) == cur.flags[3]))
                            begin
                                req.cycles = 5'd12;
                                req.addr = rel_pc;
                                nxt.pc = rel_pc + 16'd1;
                            end
                        end
                    8'hFE, 8'hBE:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.flags = sub_flags(cur.a, rdata);
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                        end
                    8'h86:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.a = add_s[7:0];
                            nxt.flags = {add_s[7:0] == 8'd0, 1'b0, add_h[4], add_s[8]};
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                        end
                    8'h1A:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.a = rdata;
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                        end
                    8'h22, 8'h32, 8'h77, 8'hE2:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd8;
                        end
                    8'hE0:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP3;
                            req.addr = ebc_pkg::HIGH_PAGE | {8'd0, rdata};
                            req.wr = 1'b1;
                            req.wdata = cur.a;
                        end
                        else if (cur.phase == ebc_pkg::PH_OP3)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd12;
                        end
                    8'hF0:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP3;
                            req.addr = ebc_pkg::HIGH_PAGE | {8'd0, rdata};
                        end
                        else if (cur.phase == ebc_pkg::PH_OP3)
                        begin
                            nxt.a = rdata;
                            req.done = 1'b1;
                            req.cycles = 5'd12;
                        end
                    8'h11, 8'h21, 8'h31, 8'hEA, 8'hCD:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.operand = {8'd0, rdata};
                            nxt.phase = ebc_pkg::PH_OP3;
                        end
                        else if (cur.phase == ebc_pkg::PH_OP3)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd12;
                            case (cur.opcode)
                                8'h11: {nxt.d, nxt.e} = word;
                                8'h21: {nxt.h, nxt.l} = word;
                                8'h31: nxt.sp = word;
                                8'hEA:
                                begin
                                    req.done = 1'b0;
                                    req.cycles = 5'd0;
                                    nxt.operand = word;
                                    nxt.pc = cur.pc;
                                    nxt.phase = ebc_pkg::PH_OP4;
                                    req.addr = word;
                                    req.wr = 1'b1;
                                    req.wdata = cur.a;
                                end
                                default:
                                begin
                                    req.done = 1'b0;
                                    req.cycles = 5'd0;
                                    nxt.operand = word;
                                    nxt.pc = cur.pc;
                                    nxt.phase = ebc_pkg::PH_OP4;
                                    nxt.sp = cur.sp - 16'd1;
                                    req.addr = cur.sp - 16'd1;
                                    req.wr = 1'b1;
                                    req.wdata = cur.pc[15:8];
                                end
                            endcase
                        end
                        else if (cur.phase == ebc_pkg::PH_OP4 && cur.opcode == 8'hEA)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd16;
                        end
                        else if (cur.phase == ebc_pkg::PH_OP4 && cur.opcode == 8'hCD)
                        begin
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP5;
                            nxt.sp = cur.sp - 16'd1;
                            req.addr = cur.sp - 16'd1;
                            req.wr = 1'b1;
                            req.wdata = cur.pc[7:0];
                        end
                        else if (cur.phase == ebc_pkg::PH_OP5 && cur.opcode == 8'hCD)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd24;
                            req.addr = cur.operand;
                            nxt.pc = cur.operand + 16'd1;
                        end
                    8'hC1, 8'hC9:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            if (cur.opcode == 8'hC1)
                                nxt.c = rdata;
                            else
                                nxt.operand = {8'd0, rdata};
                            req.addr = cur.sp;
                            nxt.sp = cur.sp + 16'd1;
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP3;
                        end
                        else if (cur.phase == ebc_pkg::PH_OP3)
                        begin
                            req.done = 1'b1;
                            if (cur.opcode == 8'hC1)
                            begin
                                nxt.b = rdata;
                                req.cycles = 5'd12;
                            end
                            else
                            begin
                                req.cycles = 5'd16;
                                req.addr = word;
                                nxt.pc = word + 16'd1;
                            end
                        end
                    8'hC5:
                        if (cur.phase == ebc_pkg::PH_OP2)
                        begin
                            nxt.sp = cur.sp - 16'd1;
                            req.addr = cur.sp - 16'd1;
                            req.wr = 1'b1;
                            req.wdata = cur.c;
                            nxt.pc = cur.pc;
                            nxt.phase = ebc_pkg::PH_OP3;
                        end
                        else if (cur.phase == ebc_pkg::PH_OP3)
                        begin
                            req.done = 1'b1;
                            req.cycles = 5'd16;
                        end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

FILE: design/eight_bit_cpu_core_subset.sv
// ---------------------------------------------------------------------------
// eight_bit_cpu_core_subset
// Bus-master core for an 8-bit CPU opcode subset, one bus cycle per request.
// ---------------------------------------------------------------------------
// channel  | valid      | ready      | payload
// ---------+------------+------------+-----------------------------------------
// in       | in_valid   | in_ready   | bus_read_data
// out      | out_valid  | out_ready  | bus_address .. pc_value
//
// Each request is registered: the step logic runs between the state
// registers and the result register. A new request is taken every cycle
// while the result register is empty or being drained this cycle.
// Reset clears all CPU state to zero, which is the reset phase (PH_RESET).
// A stalled output holds its result and blocks only further input.
module eight_bit_cpu_core_subset
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  bus_read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] bus_address,
    output logic        bus_write,
    output logic [7:0]  bus_write_data,
    output logic        instr_done,
    output logic [4:0]  instr_cycles,
    output logic        bad_opcode,
    output logic [7:0]  acc_value,
    output logic [3:0]  flag_nibble,
    output logic [15:0] pc_value
);

`include "eight_bit_cpu_core_subset_assert.svh"

    ebc_pkg::cpu_state_t state_reg;
    ebc_pkg::cpu_state_t state_next;
    ebc_pkg::bus_req_t   req_next;
    ebc_pkg::bus_req_t   req_reg;
    logic [7:0]          acc_reg;
    logic [3:0]          flag_reg;
    logic [15:0]         pc_reg;
    logic                valid_reg;
    logic                take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    ebc_exec u_exec
    (
        .cur   (state_reg),
        .rdata (bus_read_data),
        .nxt   (state_next),
        .req   (req_next)
    );

    // advance CPU state on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                state_reg <= state_next;
            if (take)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg  <= req_next;
            acc_reg  <= state_next.a;
            flag_reg <= state_next.flags;
            pc_reg   <= state_next.pc;
        end
    end

    assign out_valid      = valid_reg;
    assign bus_address    = req_reg.addr;
    assign bus_write      = req_reg.wr;
    assign bus_write_data = req_reg.wr ? req_reg.wdata : 8'd0;
    assign instr_done     = req_reg.done;
    assign instr_cycles   = req_reg.cycles;
    assign bad_opcode     = req_reg.bad;
    assign acc_value      = acc_reg;
    assign flag_nibble    = flag_reg;
    assign pc_value       = pc_reg;

    `EBC_ASSERT(a_cyc_done, clk, rst_n, out_valid |-> (instr_done == (instr_cycles != 5'd0)), "cycle count without completion")
    `EBC_ASSERT(a_bad_cyc, clk, rst_n, (out_valid && bad_opcode) |-> (instr_cycles == 5'd4), "bad opcode with wrong count")
    `EBC_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(state_reg), "state moved while stalled")

endmodule
